@@ design/ptct_pkg.sv @@
// Shared types and constants for the per-id traffic counter table.
package ptct_pkg;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_READ = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  localparam int unsigned IdW      = 16;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned CntW     = 32;
  localparam int unsigned BytesW   = 48;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 216;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Classified work item handed from the front to the back.
  typedef struct packed {
    logic             rd;
    logic             snd;
    logic             id_ok;
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [CntW-1:0]   sc;
    logic [CntW-1:0]   rc;
    logic [BytesW-1:0] sb;
    logic [BytesW-1:0] rb;
    logic [SizeW-1:0]  pk;
  } entry_t;

  // Result word, declared in reverse stream order (last field at the lowest bits).
  typedef struct packed {
    logic [SizeW-1:0]  largest_size;
    logic [BytesW-1:0] recv_bytes;
    logic [BytesW-1:0] send_bytes;
    logic [CntW-1:0]   recv_count;
    logic [CntW-1:0]   send_count;
    logic              had_traffic;
    logic              id_valid;
    logic [IdW-1:0]    message_id_res;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage

@@ design/ptct_front.sv @@
// Front end: enable register, input classification and filtering.
module ptct_front #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_data_i,
  input  logic                         in_valid_i,
  input  logic [1:0]                   in_op_i,
  input  logic [ptct_pkg::IdW-1:0]     in_id_i,
  input  logic [ptct_pkg::SizeW-1:0]   in_size_i,
  input  logic                         clr_busy_i,
  input  ptct_pkg::q_stat_t            q_stat_i,
  output logic                         in_ready_o,
  output logic                         push_o,
  output ptct_pkg::cmd_t               cmd_o
);

  logic en_q, en_d;
  logic id_ok, is_evt, is_rd, keep;

  assign en_d = cfg_valid_i ? cfg_data_i : en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= en_d;
    end
  end

  always_comb begin
    id_ok  = {1'b0, in_id_i} < (ptct_pkg::IdW + 1)'(ENTRIES);
    is_rd  = (in_op_i == ptct_pkg::OP_READ);
    is_evt = (in_op_i == ptct_pkg::OP_SEND) || (in_op_i == ptct_pkg::OP_RECV);
    // drop disabled or out-of-range events and the reserved code
    keep   = is_rd || (is_evt && en_q && id_ok);
  end

  assign in_ready_o = !clr_busy_i && !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o && keep;

  always_comb begin
    cmd_o.rd    = is_rd;
    cmd_o.snd   = (in_op_i == ptct_pkg::OP_SEND);
    cmd_o.id_ok = id_ok;
    cmd_o.id    = in_id_i;
    cmd_o.size  = in_size_i;
  end

endmodule

@@ design/ptct_queue.sv @@
// Short command queue between front and back.
module ptct_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ptct_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output ptct_pkg::cmd_t    head_o,
  output ptct_pkg::q_stat_t stat_o
);

  ptct_pkg::cmd_t                   slot_q [ptct_pkg::QueueDepth];
  logic [ptct_pkg::QPtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [ptct_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign stat_o.full  = (cnt_q == ptct_pkg::QCntW'(ptct_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == ptct_pkg::QPtrW'(ptct_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == ptct_pkg::QPtrW'(ptct_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

@@ design/ptct_back.sv @@
// Back end: counter memory, clearing pass, read-modify-write and result register.
module ptct_back #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptct_pkg::cmd_t        head_i,
  input  ptct_pkg::q_stat_t     q_stat_i,
  output logic                  pop_o,
  output logic                  clr_busy_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ptct_pkg::res_t        res_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  ptct_pkg::entry_t     mem [ENTRIES];
  ptct_pkg::entry_t     rd_data_q;
  ptct_pkg::entry_t     upd;
  ptct_pkg::cmd_t       cmd_q;
  ptct_pkg::res_t       res_q, res_d;
  logic [1:0]           st_q, st_d;
  logic [IdxW-1:0]      clr_idx_q, clr_idx_d;
  logic                 out_v_q, out_v_d;
  logic                 we;
  logic [IdxW-1:0]      waddr;
  ptct_pkg::entry_t     wdata;
  logic [ptct_pkg::BytesW:0] bsum;

  assign clr_busy_o  = (st_q == S_CLR);
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

  // Take a command when idle; a read needs the result register free.
  assign pop_o = (st_q == S_IDLE) && !q_stat_i.empty &&
                 (!head_i.rd || !out_v_q || res_ready_i);

  // Update of the fetched entry for an event
  always_comb begin
    upd  = rd_data_q;
    if (cmd_q.snd) begin
      bsum   = {1'b0, rd_data_q.sb} + (ptct_pkg::BytesW + 1)'(cmd_q.size);
      upd.sc = (rd_data_q.sc == '1) ? rd_data_q.sc : rd_data_q.sc + 1'b1;
      upd.sb = bsum[ptct_pkg::BytesW] ? '1 : bsum[ptct_pkg::BytesW-1:0];
    end else begin
      bsum   = {1'b0, rd_data_q.rb} + (ptct_pkg::BytesW + 1)'(cmd_q.size);
      upd.rc = (rd_data_q.rc == '1) ? rd_data_q.rc : rd_data_q.rc + 1'b1;
      upd.rb = bsum[ptct_pkg::BytesW] ? '1 : bsum[ptct_pkg::BytesW-1:0];
    end
    if (cmd_q.size > rd_data_q.pk) begin
      upd.pk = cmd_q.size;
    end
  end

  always_comb begin
    st_d      = st_q;
    clr_idx_d = clr_idx_q;
    out_v_d   = out_v_q && !res_ready_i;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = cmd_q.id[IdxW-1:0];
    wdata     = upd;
    case (st_q)
      S_CLR: begin
        we        = 1'b1;
        waddr     = clr_idx_q;
        wdata     = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == IdxW'(ENTRIES - 1)) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop_o) begin
          st_d = S_EXE;
        end
      end
      S_EXE: begin
        st_d = S_IDLE;
        if (cmd_q.rd) begin
          we    = cmd_q.id_ok;
          wdata = '0;
          out_v_d = 1'b1;
          res_d.message_id_res = cmd_q.id;
          res_d.id_valid       = cmd_q.id_ok;
          if (cmd_q.id_ok) begin
            res_d.had_traffic  = (rd_data_q.sc != '0) || (rd_data_q.rc != '0);
            res_d.send_count   = rd_data_q.sc;
            res_d.recv_count   = rd_data_q.rc;
            res_d.send_bytes   = rd_data_q.sb;
            res_d.recv_bytes   = rd_data_q.rb;
            res_d.largest_size = rd_data_q.pk;
          end else begin
            res_d.had_traffic  = 1'b0;
            res_d.send_count   = '0;
            res_d.recv_count   = '0;
            res_d.send_bytes   = '0;
            res_d.recv_bytes   = '0;
            res_d.largest_size = '0;
          end
        end else begin
          we = 1'b1;
        end
      end
      default: begin
        st_d = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLR;
      clr_idx_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      clr_idx_q <= clr_idx_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      cmd_q <= head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_data_q <= mem[head_i.id[IdxW-1:0]];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ design/per_id_traffic_counter_table.sv @@
// Top level of the per-id traffic counter table.
//
// Input stream (s_axis_*): one transaction per item. tuser carries the op
// (send event, receive event, read-and-clear); tdata carries the message id
// and the byte size. Events that are disabled, out of range or carry the
// reserved op are dropped at the front and produce nothing.
// Output stream (m_axis_*): one transaction per read-and-clear, with the
// entry's counters, its traffic flag and whether the id was inside the table.
// Configuration (cfg_*): a one-bit enable write, always ready; write it only
// while the block is idle.
//
// Back end: an item is popped in the idle state, which registers the memory
// read, and written back in the execute state; the next item is popped only
// in idle again. A read-and-clear goes through the queue, the back end's
// command and read-data registers and the result register to m_axis.
// Reset: the counter memory is zeroed by a clearing pass over all ENTRIES
// entries, one entry a cycle; s_axis_tready_o stays low during it.
// Output stall: the result register holds until taken; events flow until a
// read heads the two-entry queue, which fills; then s_axis_tready_o drops.
module per_id_traffic_counter_table #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,    // enable
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: message_id[15:0], byte_size[47:16]
  input  logic [ptct_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: op[1:0]
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: message_id_res[15:0], id_valid[16], had_traffic[17],
  // send_count[49:18], recv_count[81:50], send_bytes[129:82],
  // recv_bytes[177:130], largest_size[209:178], zero fill to 215
  output logic [ptct_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  ptct_pkg::cmd_t    push_cmd;
  ptct_pkg::cmd_t    head;
  ptct_pkg::q_stat_t q_stat;
  ptct_pkg::res_t    res;
  logic              push, pop, clr_busy;

  assign cfg_ready_o = 1'b1;

  // Classify and filter incoming transactions
  ptct_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_id_i    (s_axis_tdata_i[15:0]),
    .in_size_i  (s_axis_tdata_i[47:16]),
    .clr_busy_i (clr_busy),
    .q_stat_i   (q_stat),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouple the front from the memory pipeline
  ptct_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // Execute updates and read-and-clear against the counter memory
  ptct_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .clr_busy_o (clr_busy),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {(ptct_pkg::OutDataW - ptct_pkg::ResW)'(0), res};

  // No result may exist while the memory is still being cleared.
  a_no_result_in_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy |-> !m_axis_tvalid_o
  ) else $error("result valid during clearing pass");

  // The front must never push into a full queue.
  a_no_push_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_stat.full |-> !push
  ) else $error("push into full queue");

  // An out-of-range read reports all counters as zero.
  a_invalid_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[16]) |-> (m_axis_tdata_o[209:17] == '0)
  ) else $error("out-of-range read returned nonzero counters");

endmodule

@@ test/traffic_table_checker.sv @@
// Checker for the per-id traffic counter table: mirrors the counters and scores each read.
module traffic_table_checker
  import ptct_pkg::*;
#(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,    // enable
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,     // message_id, byte_size
  input  logic [1:0]          s_tuser_i,     // op
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,     // res_t in the low bits, zero fill above
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  localparam logic [CntW-1:0]   CntMax   = '1;
  localparam logic [BytesW-1:0] BytesMax = '1;

  logic [CntW-1:0]   sent_cnt   [ENTRIES];
  logic [CntW-1:0]   recv_cnt   [ENTRIES];
  logic [BytesW-1:0] sent_bytes [ENTRIES];
  logic [BytesW-1:0] recv_bytes [ENTRIES];
  logic [SizeW-1:0]  peak_len   [ENTRIES];
  logic              enabled;
  res_t              reads_due[$];
  int unsigned       fail_cnt = 0;

  assign errors_o = fail_cnt;

  function automatic logic [BytesW-1:0] add_bytes_sat(logic [BytesW-1:0] acc,
                                                      logic [SizeW-1:0] sz);
    logic [BytesW:0] sum;
    sum = {1'b0, acc} + {{(BytesW + 1 - SizeW){1'b0}}, sz};
    return sum[BytesW] ? BytesMax : sum[BytesW-1:0];
  endfunction

  // Apply one transaction to the mirrored table; return 1 with a snapshot for a read.
  function automatic bit apply_traffic_item(op_e op, logic [IdW-1:0] id,
                                            logic [SizeW-1:0] sz, output res_t snap);
    bit in_tbl;
    bit produced;
    in_tbl   = 32'(id) < ENTRIES;
    produced = 1'b0;
    snap     = '0;
    case (op)
      OP_SEND, OP_RECV: begin
        if (enabled && in_tbl) begin
          if (op == OP_SEND) begin
            if (sent_cnt[id] != CntMax) sent_cnt[id] = sent_cnt[id] + 1'b1;
            sent_bytes[id] = add_bytes_sat(sent_bytes[id], sz);
          end else begin
            if (recv_cnt[id] != CntMax) recv_cnt[id] = recv_cnt[id] + 1'b1;
            recv_bytes[id] = add_bytes_sat(recv_bytes[id], sz);
          end
          if (sz > peak_len[id]) peak_len[id] = sz;
        end
      end
      OP_READ: begin
        produced            = 1'b1;
        snap.message_id_res = id;
        snap.id_valid       = in_tbl;
        if (in_tbl) begin
          snap.had_traffic  = (sent_cnt[id] != '0) || (recv_cnt[id] != '0);
          snap.send_count   = sent_cnt[id];
          snap.recv_count   = recv_cnt[id];
          snap.send_bytes   = sent_bytes[id];
          snap.recv_bytes   = recv_bytes[id];
          snap.largest_size = peak_len[id];
          sent_cnt[id]   = '0;
          recv_cnt[id]   = '0;
          sent_bytes[id] = '0;
          recv_bytes[id] = '0;
          peak_len[id]   = '0;
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  task automatic score_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t snap;
    res_t want;
    res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        sent_cnt[i]   = '0;
        recv_cnt[i]   = '0;
        sent_bytes[i] = '0;
        recv_bytes[i] = '0;
        peak_len[i]   = '0;
      end
      enabled = 1'b0;
      reads_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) enabled = cfg_data_i;
      // Score the outgoing transaction before adding this edge's read.
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[ResW-1:0]);
        if (reads_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, got);
          fail_cnt++;
        end else begin
          want = reads_due.pop_front();
          score_field("message_id_res", 64'(want.message_id_res),
                      64'(got.message_id_res));
          score_field("id_valid", 64'(want.id_valid), 64'(got.id_valid));
          score_field("had_traffic", 64'(want.had_traffic), 64'(got.had_traffic));
          score_field("send_count", 64'(want.send_count), 64'(got.send_count));
          score_field("recv_count", 64'(want.recv_count), 64'(got.recv_count));
          score_field("send_bytes", 64'(want.send_bytes), 64'(got.send_bytes));
          score_field("recv_bytes", 64'(want.recv_bytes), 64'(got.recv_bytes));
          score_field("largest_size", 64'(want.largest_size), 64'(got.largest_size));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (apply_traffic_item(op_e'(s_tuser_i), s_tdata_i[IdW-1:0],
                               s_tdata_i[IdW +: SizeW], snap))
          reads_due.insert(reads_due.size(), snap);
      end
      pending_o <= reads_due.size();
    end
  end

endmodule

@@ test/per_id_traffic_counter_table_tb.sv @@
// Testbench top for the per-id traffic counter table: clock, reset, stimulus and verdict.
module per_id_traffic_counter_table_tb;
  import ptct_pkg::*;

  localparam int unsigned ENTRIES        = 256;
  // Cycles to let queued events drain out of the pipeline after the last read.
  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned LongHoldCycles = 150;
  // Bound for the slowest legal run, clearing pass included.
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned HotIds         = 8;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_data  = 1'b0;
  logic                s_valid   = 1'b0;
  logic [InDataW-1:0]  s_data    = '0;
  logic [1:0]          s_user    = '0;
  logic                m_ready   = 1'b0;
  logic                cfg_ready;
  logic                s_ready;
  logic                m_valid;
  logic [OutDataW-1:0] m_data;

  int unsigned errors;
  int unsigned pending;
  // Idling on both sides is allowed while this is set.
  bit          gaps_on     = 1'b1;
  // Ask the receiver for one long hold-off.
  bit          rx_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_id_traffic_counter_table #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  traffic_table_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_ready),
    .s_tdata_i  (s_data),
    .s_tuser_i  (s_user),
    .m_tvalid_i (m_valid),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Hold tvalid low for a number of cycles.
  task automatic rest_sender(int unsigned cycles_n);
    s_valid <= 1'b0;
    repeat (cycles_n) @(posedge clk);
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic push_item(op_e op, logic [IdW-1:0] id, logic [SizeW-1:0] sz);
    if (gaps_on && $urandom_range(0, 5) == 0) rest_sender($urandom_range(1, 17));
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {sz, id};
    do @(posedge clk); while (!s_ready);
  endtask

  // Stop sending, wait for every expected read, then let queued events retire.
  task automatic settle_block();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_enable(logic en);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a few hot ids so counters build up between reads; some ids far out of range.
  task automatic draw_traffic_item(output op_e op, output logic [IdW-1:0] id,
                                   output logic [SizeW-1:0] sz);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38)      op = OP_SEND;
    else if (pick < 68) op = OP_RECV;
    else if (pick < 95) op = OP_READ;
    else                op = OP_RSVD;
    pick = $urandom_range(0, 99);
    if (pick < 55)      id = IdW'($urandom_range(0, HotIds - 1));
    else if (pick < 70) id = IdW'($urandom_range(ENTRIES - 4, ENTRIES - 1));
    else if (pick < 92) id = IdW'($urandom_range(0, ENTRIES - 1));
    else                id = IdW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 10)      sz = '0;
    else if (pick < 20) sz = '1;
    else if (pick < 60) sz = SizeW'($urandom_range(0, 1500));
    else                sz = $urandom();
  endtask

  // Random traffic with an occasional window snapshot sweep over the hot ids.
  task automatic run_traffic(int unsigned n);
    op_e               op;
    logic [IdW-1:0]    id;
    logic [SizeW-1:0]  sz;
    int unsigned       k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 39) == 0) begin
        for (int i = 0; i < HotIds; i++) push_item(OP_READ, IdW'(i), $urandom());
        k += HotIds;
      end else begin
        draw_traffic_item(op, id, sz);
        push_item(op, id, sz);
        k++;
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none in the calm tail.
  initial begin : rx_side
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_done) begin
        m_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        m_ready <= 1'b1;
        hold_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    op_e              op;
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] sz;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: the event is dropped, the read still answers with zeros.
    push_item(OP_SEND, 16'd3, 32'd100);
    push_item(OP_READ, 16'd3, 32'd0);
    write_enable(1'b1);

    // A zero-size send still counts as traffic; all-ones size sets the peak.
    push_item(OP_SEND, 16'd0, 32'd0);
    push_item(OP_SEND, 16'd0, 32'hFFFF_FFFF);
    push_item(OP_RECV, 16'd0, 32'd1);
    push_item(OP_READ, 16'd0, 32'hFFFF_FFFF);
    // Read right after a clear: everything back to zero.
    push_item(OP_READ, 16'd0, 32'd0);
    // Peak from the receive side only, and a smaller size does not lower it.
    push_item(OP_RECV, IdW'(ENTRIES - 1), 32'h8000_0000);
    push_item(OP_RECV, IdW'(ENTRIES - 1), 32'h7FFF_FFFF);
    push_item(OP_READ, IdW'(ENTRIES - 1), 32'd0);
    // Out-of-range events and the reserved op change nothing.
    push_item(OP_SEND, IdW'(ENTRIES), 32'd5);
    push_item(OP_RECV, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(OP_RSVD, 16'd1, 32'd9);
    push_item(OP_RSVD, 16'hFFFF, 32'hFFFF_FFFF);
    // Out-of-range reads answer with id_valid low, next to an in-range read of id 1.
    push_item(OP_READ, IdW'(ENTRIES), 32'd0);
    push_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(OP_READ, 16'd1, 32'd0);
    push_item(OP_READ, 16'hAAAA, 32'h5555_5555);

    run_traffic(100);
    // Long receiver hold-off with the sender offering back to back: the block fills.
    rx_hold_req = 1'b1;
    gaps_on     = 1'b0;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) begin
        push_item(OP_READ, IdW'(i % HotIds), $urandom());
      end else begin
        draw_traffic_item(op, id, sz);
        push_item(op, id, sz);
      end
    end
    gaps_on = 1'b1;
    run_traffic(400);

    // Disabled window: events drop, reads still drain what was counted.
    write_enable(1'b0);
    run_traffic(100);

    write_enable(1'b1);
    run_traffic(300);
    // Calm tail: no idling on either side.
    gaps_on = 1'b0;
    run_traffic(160);

    settle_block();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
